>>> sv/hash_set_bucket_table_defines.svh
// ---------------------------------------------------------------------------
// Hash set bucket table: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef HASH_SET_BUCKET_TABLE_DEFINES_SVH
`define HASH_SET_BUCKET_TABLE_DEFINES_SVH

// Same-cycle implication: cond holds whenever trig holds.
`define HSBT_ASSERT_IMP(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Next-cycle implication: cond holds in the cycle after trig.
`define HSBT_ASSERT_NXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> sv/hsbt_pkg.sv
// ---------------------------------------------------------------------------
// Hash set bucket table: package
// Sizes, operation codes, row layout and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package hsbt_pkg;

  localparam int unsigned BUCKETS     = 1024;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned KEY_W       = 20;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SLOT_W      = KEY_W + 1;          // {valid, key}
  localparam int unsigned ROW_W       = WAYS * SLOT_W;
  localparam int unsigned IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W  = FUNC_W;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [BKT_W-1:0]  bkt_t;
  typedef logic [ROW_W-1:0]  row_t;

  localparam func_t FUNC_ADD      = 2'd0;
  localparam func_t FUNC_REMOVE   = 2'd1;
  localparam func_t FUNC_CONTAINS = 2'd2;

  typedef struct packed {
    logic found;
    logic bucket_full;
    logic wr_en;
  } hsbt_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

endpackage

`default_nettype wire

>>> sv/hsbt_ram.sv
// ---------------------------------------------------------------------------
// Hash set bucket table: generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hsbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/hsbt_match.sv
// ---------------------------------------------------------------------------
// Hash set bucket table: bucket match and update
// Compare a key against one bucket row, pick the hit and free slots, and
// build the row to write back.
// ---------------------------------------------------------------------------
`default_nettype none

module hsbt_match (
  input  wire hsbt_pkg::func_t   func,
  input  wire hsbt_pkg::key_t    key,
  input  wire hsbt_pkg::row_t    row,
  output hsbt_pkg::row_t         row_new,
  output hsbt_pkg::hsbt_res_t    res
);
  import hsbt_pkg::*;

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0] slot_vld;
  logic [WAYS-1:0] slot_eq;
  logic            hit;
  logic            have_free;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;

  always_comb begin
    for (int w = 0; w < int'(WAYS); w++) begin
      slot_vld[w] = row[w*SLOT_W + KEY_W];
      slot_eq[w]  = slot_vld[w] && (row[w*SLOT_W +: KEY_W] == key);
    end
  end

  // Priority pick: lowest-numbered match and lowest-numbered free slot.
  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < int'(WAYS); w++) begin
      if (slot_eq[w] && !hit) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!slot_vld[w] && !have_free) begin
        have_free = 1'b1;
        free_way  = WAY_W'(w);
      end
    end
  end

  always_comb begin
    row_new         = row;
    res.found       = hit;
    res.bucket_full = 1'b0;
    res.wr_en       = 1'b0;
    case (func)
      FUNC_ADD: begin
        if (!hit) begin
          if (have_free) begin
            row_new[free_way*SLOT_W +: SLOT_W] = {1'b1, key};
            res.wr_en = 1'b1;
          end else begin
            res.bucket_full = 1'b1;
          end
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          row_new[hit_way*SLOT_W + KEY_W] = 1'b0;
          res.wr_en = 1'b1;
        end
      end
      default: begin
        // contains, and the unused code acting as contains: no change
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/hash_set_bucket_table.sv
// ---------------------------------------------------------------------------
// Hash set bucket table
// Set of 20-bit keys with add, remove and contains requests over a bucketed
// table held in one synchronous RAM.
// ---------------------------------------------------------------------------
// Each request returns one result telling whether the key was in the set
// before the request, and for an add of a new key whose bucket has no free
// slot, a bucket_full flag (the set is then unchanged). The bucket is the key
// modulo BUCKETS; each bucket holds WAYS slots stored as one RAM row, so a
// request costs one row read and at most one row write. The transfer cycle
// issues the row read, and the LOOKUP state then compares the row and writes
// it back, so the next request is taken in the cycle after the write.
// Results sit in an output register, so a new request is taken while the
// previous result still waits; the compare stage holds only if that register
// is still full. After reset the block sweeps all BUCKETS (1024) bucket rows,
// one row per cycle, with in_tready low.
// Operation code 3 acts as contains. Any 20-bit key is accepted.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hash_set_bucket_table_defines.svh"

module hash_set_bucket_table (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [hsbt_pkg::IN_TDATA_W-1:0]    in_tdata,   // [19:0] key
  input  wire logic [hsbt_pkg::IN_TUSER_W-1:0]    in_tuser,   // [1:0] func
  // result channel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [hsbt_pkg::OUT_TDATA_W-1:0]        out_tdata   // [0] found, [1] bucket_full
);
  import hsbt_pkg::*;

  state_t    state_r, state_nxt;
  bkt_t      clr_addr_r, clr_addr_nxt;
  func_t     func_r;
  key_t      key_r;
  logic      out_valid_r, out_valid_nxt;
  logic [1:0] out_flags_r;

  logic      in_xfer;
  logic      lookup_go;
  key_t      in_key;
  bkt_t      rd_bkt;
  bkt_t      wr_bkt;

  logic      ram_we;
  bkt_t      ram_waddr;
  row_t      ram_wdata;
  row_t      ram_rdata;
  row_t      row_new;
  hsbt_res_t res;

  // Accept only in idle; the clearing pass and the compare cycle hold off.
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_key    = in_tdata[KEY_W-1:0];

  // Bucket index: key modulo the bucket count.
  assign rd_bkt = BKT_W'(in_key % BUCKETS);
  assign wr_bkt = BKT_W'(key_r % BUCKETS);

  // Advance the compare stage once the result register is free or draining.
  assign lookup_go = (state_r == ST_LOOKUP) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lookup_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Hold the request for the compare cycle.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_tuser[FUNC_W-1:0];
      key_r  <= in_key;
    end
  end

  // RAM write: zero rows during the sweep, else write back the updated row.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = lookup_go && res.wr_en;
      ram_waddr = wr_bkt;
      ram_wdata = row_new;
    end
  end

  hsbt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (rd_bkt),
    .rdata (ram_rdata)
  );

  // Read data holds while the compare stage stalls: no new read is issued.
  hsbt_match u_match (
    .func    (func_r),
    .key     (key_r),
    .row     (ram_rdata),
    .row_new (row_new),
    .res     (res)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (lookup_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_go) begin
      out_flags_r <= {res.bucket_full, res.found};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_flags_r};

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `HSBT_ASSERT_NXT(a_xfer_to_lookup, in_xfer, state_r == ST_LOOKUP, "transfer did not start lookup")
  `HSBT_ASSERT_NXT(a_go_loads_out, lookup_go, out_valid_r, "lookup finished without a result")
  `HSBT_ASSERT_IMP(a_full_not_found, lookup_go && res.bucket_full, !res.found, "full flag on a hit")
  `HSBT_ASSERT_IMP(a_full_only_add, lookup_go && res.bucket_full, func_r == FUNC_ADD, "full flag on non-add")
  `HSBT_ASSERT_IMP(a_no_write_on_read, in_xfer, !ram_we, "row write during row read")

endmodule

`default_nettype wire
